/* rtl/bsre_pkg.sv */
// shared types, codes and helpers for the bitmap sketch run-length encoder
`timescale 1ns / 1ps

package bsre_pkg;

    localparam int THUMB_BYTES_DEF    = 80;
    localparam int MAX_SIDE_BYTES_DEF = 40;
    localparam int OUT_FIFO_DEPTH     = 8;
    localparam int MAX_RES            = 3;
    localparam int ADDR_W             = 14;
    localparam int CAND_W             = 10;
    localparam int TD_DONE_BIT        = 36;

    localparam logic [5:0] SIDE_RESET  = 6'd20;
    localparam logic [1:0] SCALE_RESET = 2'd1;

    localparam logic [7:0] HDR_WHITE   = 8'h00;
    localparam logic [7:0] HDR_BLACK   = 8'h80;
    localparam logic [7:0] HDR_MIXED   = 8'hc0;
    localparam logic [7:0] HDR_BLACK2  = 8'h81;
    localparam logic [7:0] HDR_WHITE2  = 8'h01;
    localparam logic [5:0] CNT_MAX_RUN = 6'd63;
    localparam logic [7:0] CNT_MAX_WHT = 8'd127;
    localparam logic [7:0] BYTE_BLACK  = 8'hff;
    localparam logic [7:0] BYTE_WHITE  = 8'h00;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_THUMB = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_THUMB  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic {
        REG_SIDE_BYTES  = 1'b0,
        REG_THUMB_SCALE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          data;
        logic [ADDR_W-1:0]   size;
        logic                done;
        logic                last;
    } bsre_result_t;

    typedef struct packed {
        logic [1:0]                  n;
        bsre_result_t [MAX_RES-1:0]  res;
    } bsre_bundle_t;

    typedef struct packed {
        logic              rd;
        logic              mk;
        logic              ok;
        logic [CAND_W-1:0] idx;
        logic [7:0]        mask;
    } bsre_thumb_op_t;

    // x / s for s in 1..3, x below 128; zero scale acts as one
    function automatic logic [7:0] bsre_div_scale(input logic [7:0] x, input logic [1:0] s);
        logic [15:0] prod;
        logic [7:0]  q;
        prod = 16'(x) * 16'd43;
        case (s)
            2'd2:    q = x >> 1;
            2'd3:    q = prod[14:7];
            default: q = x;
        endcase
        return q;
    endfunction

endpackage

/* rtl/bitmap_sketch_rle_encoder_unit.sv */
// top level of the bitmap sketch run-length encoder
`timescale 1ns / 1ps

// Encodes a square 1-bit bitmap, fed a byte per input beat in raster order, into a
// stream of buffer writes (header bytes, literal bytes and in-place header patches)
// behind a thumbnail area, while building a coarse thumbnail that can be read back.
// An input beat is taken every cycle as long as the output queue, counting the beats
// still held in the merge stage, has room for three more beats. A pixel beat yields
// one to three output beats; the output side moves one beat per cycle while m_tready
// is high, so over a long stream the pixel rate equals the output rate divided by the
// writes per byte (one to three). Results pass through a first stage that updates the
// run state and reads the thumbnail memory and a merge stage that merges the read data
// (read-modify-write with forwarding of the previous write) and queues the results.
// Thumbnail entries are cleared at a frame start through per-entry valid bits, with no
// sweep. Configuration registers: side_bytes at address 0, thumb_scale at address 4;
// the user must write them only while idle, which the block itself does not enforce.
module bitmap_sketch_rle_encoder_unit #(
    parameter int THUMB_BYTES    = bsre_pkg::THUMB_BYTES_DEF,
    parameter int MAX_SIDE_BYTES = bsre_pkg::MAX_SIDE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // pixel_byte[7:0], thumb_addr[14:8], zero pad
    input  logic [1:0]  s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // out_addr[13:0], out_data[21:14],
                                    // encoded_size[35:22], frame_done[36], zero pad
    output logic [1:0]  m_tuser,    // out_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bsre_pkg::*;

    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    logic [5:0]     side_bytes_reg;
    logic [1:0]     thumb_scale_reg;
    logic           accept;
    logic           clear;
    bsre_bundle_t   a_bundle;
    bsre_thumb_op_t a_op;
    bsre_bundle_t   b_bundle_reg;
    logic           b_vld_reg;
    bsre_bundle_t   push;
    logic [7:0]     thumb_rdata;
    bsre_result_t   head;
    logic           head_valid;
    logic [CNT_W-1:0] fifo_count;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_bytes_reg  <= SIDE_RESET;
            thumb_scale_reg <= SCALE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_SIDE_BYTES:  side_bytes_reg  <= pwdata[5:0];
                REG_THUMB_SCALE: thumb_scale_reg <= pwdata[1:0];
                default:         side_bytes_reg  <= side_bytes_reg;
            endcase
        end
    end

    assign prdata = (reg_idx_t'(paddr[2]) == REG_THUMB_SCALE) ? 32'(thumb_scale_reg) :
                                                                32'(side_bytes_reg);

    // room for whatever sits in the merge stage plus a worst-case new item
    assign s_tready = (32'(fifo_count) + 32'(b_vld_reg ? b_bundle_reg.n : 2'd0) + MAX_RES)
                      <= OUT_FIFO_DEPTH;
    assign accept   = s_tvalid && s_tready;

    bsre_encoder #(
        .THUMB_BYTES    (THUMB_BYTES),
        .MAX_SIDE_BYTES (MAX_SIDE_BYTES)
    ) u_encoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (req_t'(s_tuser)),
        .pixel       (s_tdata[7:0]),
        .taddr       (s_tdata[14:8]),
        .side_bytes  (side_bytes_reg),
        .thumb_scale (thumb_scale_reg),
        .bundle      (a_bundle),
        .thumb_op    (a_op),
        .clear       (clear)
    );

    bsre_thumb #(
        .THUMB_BYTES (THUMB_BYTES)
    ) u_thumb (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept && clear),
        .op_valid (accept),
        .op       (a_op),
        .rdata    (thumb_rdata)
    );

    // merge stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        b_bundle_reg <= a_bundle;
    end

    always_comb
    begin
        push = b_bundle_reg;
        if (!b_vld_reg)
        begin
            push.n = 2'd0;
        end
        if (b_bundle_reg.res[0].kind == KIND_THUMB)
        begin
            push.res[0].data = thumb_rdata;
        end
    end

    bsre_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_tvalid && m_tready),
        .head       (head),
        .head_valid (head_valid),
        .count      (fifo_count)
    );

    assign m_tvalid = head_valid;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {3'b000, head.done, head.size, head.data, head.addr};

endmodule

/* rtl/bsre_thumb.sv */
// thumbnail store: registered-read memory with read-modify-write and forwarding
`timescale 1ns / 1ps

module bsre_thumb #(
    parameter int THUMB_BYTES = bsre_pkg::THUMB_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    op_valid,
    input  bsre_pkg::bsre_thumb_op_t op,
    output logic [7:0]              rdata
);
    import bsre_pkg::*;

    localparam int IDX_W = $clog2(THUMB_BYTES);

    logic [7:0]             mem [THUMB_BYTES];
    logic [7:0]             rd_data_reg;
    logic [THUMB_BYTES-1:0] valid_reg;
    logic [THUMB_BYTES-1:0] valid_next;
    bsre_thumb_op_t         b_op_reg;
    logic                   b_vld_reg;
    logic                   last_wr_vld_reg;
    logic [IDX_W-1:0]       last_wr_idx_reg;
    logic [7:0]             last_wr_data_reg;

    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic             rd_en;
    logic             wr_en;
    logic [7:0]       base;
    logic [7:0]       wr_data;

    assign a_idx = op.idx[IDX_W-1:0];
    assign b_idx = b_op_reg.idx[IDX_W-1:0];
    assign rd_en = op_valid && op.ok && (op.rd || op.mk);

    // the entry written last cycle was not yet seen by this read
    always_comb
    begin
        if (last_wr_vld_reg && (last_wr_idx_reg == b_idx))
        begin
            base = last_wr_data_reg;
        end
        else if (valid_reg[b_idx])
        begin
            base = rd_data_reg;
        end
        else
        begin
            base = 8'h00;
        end
    end

    assign rdata   = b_op_reg.ok ? base : 8'h00;
    assign wr_en   = b_vld_reg && b_op_reg.mk && b_op_reg.ok;
    assign wr_data = base | b_op_reg.mask;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[b_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[a_idx];
        end
    end

    // frame start wins over a write still in flight
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[b_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            b_vld_reg       <= 1'b0;
            last_wr_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            b_vld_reg       <= op_valid;
            last_wr_vld_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        b_op_reg         <= op;
        last_wr_idx_reg  <= b_idx;
        last_wr_data_reg <= wr_data;
    end

endmodule

/* rtl/bsre_encoder.sv */
// run state registers and the per-byte header and literal write logic
`timescale 1ns / 1ps

module bsre_encoder #(
    parameter int THUMB_BYTES    = bsre_pkg::THUMB_BYTES_DEF,
    parameter int MAX_SIDE_BYTES = bsre_pkg::MAX_SIDE_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  bsre_pkg::req_t           req,
    input  logic [7:0]               pixel,
    input  logic [6:0]               taddr,
    input  logic [5:0]               side_bytes,
    input  logic [1:0]               thumb_scale,
    output bsre_pkg::bsre_bundle_t   bundle,
    output bsre_pkg::bsre_thumb_op_t thumb_op,
    output logic                     clear
);
    import bsre_pkg::*;

    localparam int ROW_W = $clog2(MAX_SIDE_BYTES * 8 + 1);
    localparam int COL_W = $clog2(MAX_SIDE_BYTES);
    localparam logic [ADDR_W-1:0] THUMB_BASE = ADDR_W'(THUMB_BYTES);

    logic [7:0]        run_header_reg,   run_header_next;
    logic [ADDR_W-1:0] header_addr_reg,  header_addr_next;
    logic [7:0]        last_literal_reg, last_literal_next;
    logic [ADDR_W-1:0] literal_addr_reg, literal_addr_next;
    logic [ADDR_W-1:0] byte_count_reg,   byte_count_next;
    logic [COL_W-1:0]  column_pos_reg,   column_pos_next;
    logic [ROW_W-1:0]  row_pos_reg,      row_pos_next;
    logic              seed_pending_reg, seed_pending_next;

    always_comb
    begin
        logic [5:0]        se;
        logic              full;
        logic              done;
        logic [1:0]        n;
        logic [7:0]        h;
        logic [1:0]        s;
        logic [7:0]        qc;
        logic [7:0]        qr;
        logic [CAND_W-1:0] cand;

        run_header_next   = run_header_reg;
        header_addr_next  = header_addr_reg;
        last_literal_next = last_literal_reg;
        literal_addr_next = literal_addr_reg;
        byte_count_next   = byte_count_reg;
        column_pos_next   = column_pos_reg;
        row_pos_next      = row_pos_reg;
        seed_pending_next = seed_pending_reg;
        bundle            = '0;
        thumb_op          = '0;
        clear             = 1'b0;
        n                 = 2'd0;
        done              = 1'b0;
        h                 = 8'h00;

        se   = (32'(side_bytes) > MAX_SIDE_BYTES) ? 6'(MAX_SIDE_BYTES) : side_bytes;
        full = 32'(row_pos_reg) >= 32'(se) * 8;

        // thumbnail bit for this byte
        s    = (thumb_scale == 2'd0) ? 2'd1 : thumb_scale;
        qc   = bsre_div_scale(8'(column_pos_reg), s);
        qr   = bsre_div_scale(8'(row_pos_reg >> 3), s);
        cand = (CAND_W'(qr) << 2) + CAND_W'(qc >> 3);

        unique case (req)
            REQ_START:
            begin
                clear             = 1'b1;
                run_header_next   = 8'h00;
                last_literal_next = 8'h00;
                header_addr_next  = THUMB_BASE;
                literal_addr_next = THUMB_BASE;
                byte_count_next   = THUMB_BASE;
                column_pos_next   = '0;
                row_pos_next      = '0;
                seed_pending_next = 1'b1;
            end
            REQ_THUMB:
            begin
                n             = 2'd1;
                bundle.res[0] = '{KIND_THUMB, ADDR_W'(taddr), 8'h00, byte_count_reg,
                                  full, 1'b1};
                thumb_op.rd   = 1'b1;
                thumb_op.ok   = 32'(taddr) < THUMB_BYTES;
                thumb_op.idx  = CAND_W'(taddr);
            end
            REQ_PIXEL:
            begin
                if (full)
                begin
                    n             = 2'd1;
                    bundle.res[0] = '{KIND_REJECT, '0, pixel, byte_count_reg, 1'b1, 1'b1};
                end
                else
                begin
                    thumb_op.mk   = (pixel != BYTE_WHITE);
                    thumb_op.ok   = 32'(cand) < THUMB_BYTES;
                    thumb_op.idx  = cand;
                    thumb_op.mask = 8'h80 >> qc[2:0];

                    // first byte of a frame seeds a header of the opposite kind
                    if (seed_pending_reg)
                    begin
                        seed_pending_next = 1'b0;
                        header_addr_next  = THUMB_BASE;
                        run_header_next   = (pixel != BYTE_WHITE) ? HDR_WHITE : HDR_BLACK;
                        byte_count_next   = THUMB_BASE + 1'b1;
                        bundle.res[n] = '{KIND_WRITE, header_addr_next, run_header_next,
                                          byte_count_next, 1'b0, 1'b0};
                        n = n + 2'd1;
                        literal_addr_next = header_addr_next;
                        last_literal_next = run_header_next;
                    end
                    h = run_header_next;

                    if (pixel == BYTE_BLACK)
                    begin
                        if (h[7:6] == 2'b11)
                        begin
                            if (last_literal_next == BYTE_BLACK)
                            begin
                                // two blacks end a mixed run: split them off
                                run_header_next = h - 8'd1;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                                header_addr_next = literal_addr_next;
                                run_header_next  = HDR_BLACK2;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                                last_literal_next = run_header_next;
                            end
                            else if (h[5:0] < CNT_MAX_RUN)
                            begin
                                run_header_next = h + 8'd1;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                                literal_addr_next = literal_addr_next + 1'b1;
                                last_literal_next = BYTE_BLACK;
                                byte_count_next   = byte_count_next + 1'b1;
                                bundle.res[n] = '{KIND_WRITE, literal_addr_next,
                                                  last_literal_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                            end
                            else
                            begin
                                header_addr_next = literal_addr_next + 1'b1;
                                run_header_next  = HDR_BLACK;
                                byte_count_next  = byte_count_next + 1'b1;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                            end
                        end
                        else if (h[7] && (h[5:0] < CNT_MAX_RUN))
                        begin
                            run_header_next = h + 8'd1;
                            bundle.res[n] = '{KIND_WRITE, header_addr_next, run_header_next,
                                              byte_count_next, 1'b0, 1'b0};
                            n = n + 2'd1;
                        end
                        else
                        begin
                            header_addr_next = header_addr_next + 1'b1;
                            run_header_next  = HDR_BLACK;
                            byte_count_next  = byte_count_next + 1'b1;
                            bundle.res[n] = '{KIND_WRITE, header_addr_next, run_header_next,
                                              byte_count_next, 1'b0, 1'b0};
                            n = n + 2'd1;
                        end
                    end
                    else if (pixel != BYTE_WHITE)
                    begin
                        if (h[7:6] == 2'b11)
                        begin
                            if (h[5:0] < CNT_MAX_RUN)
                            begin
                                run_header_next = h + 8'd1;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                            end
                            else
                            begin
                                header_addr_next = literal_addr_next + 1'b1;
                                run_header_next  = HDR_MIXED;
                                byte_count_next  = byte_count_next + 1'b1;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                            end
                            literal_addr_next = (header_addr_next > literal_addr_next) ?
                                                header_addr_next + 1'b1 :
                                                literal_addr_next + 1'b1;
                        end
                        else
                        begin
                            header_addr_next = header_addr_next + 1'b1;
                            run_header_next  = HDR_MIXED;
                            byte_count_next  = byte_count_next + 1'b1;
                            bundle.res[n] = '{KIND_WRITE, header_addr_next, run_header_next,
                                              byte_count_next, 1'b0, 1'b0};
                            n = n + 2'd1;
                            literal_addr_next = header_addr_next + 1'b1;
                        end
                        last_literal_next = pixel;
                        byte_count_next   = byte_count_next + 1'b1;
                        bundle.res[n] = '{KIND_WRITE, literal_addr_next, last_literal_next,
                                          byte_count_next, 1'b0, 1'b0};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        if (h[7:6] == 2'b11)
                        begin
                            if (last_literal_next != BYTE_WHITE)
                            begin
                                if (h[5:0] < CNT_MAX_RUN)
                                begin
                                    run_header_next = h + 8'd1;
                                    bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                      run_header_next, byte_count_next,
                                                      1'b0, 1'b0};
                                    n = n + 2'd1;
                                    literal_addr_next = literal_addr_next + 1'b1;
                                    last_literal_next = BYTE_WHITE;
                                    byte_count_next   = byte_count_next + 1'b1;
                                    bundle.res[n] = '{KIND_WRITE, literal_addr_next,
                                                      last_literal_next, byte_count_next,
                                                      1'b0, 1'b0};
                                    n = n + 2'd1;
                                end
                                else
                                begin
                                    header_addr_next = literal_addr_next + 1'b1;
                                    run_header_next  = HDR_WHITE;
                                    byte_count_next  = byte_count_next + 1'b1;
                                    bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                      run_header_next, byte_count_next,
                                                      1'b0, 1'b0};
                                    n = n + 2'd1;
                                end
                            end
                            else
                            begin
                                // two whites end a mixed run: split them off
                                run_header_next = h - 8'd1;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                                header_addr_next = literal_addr_next;
                                run_header_next  = HDR_WHITE2;
                                bundle.res[n] = '{KIND_WRITE, header_addr_next,
                                                  run_header_next, byte_count_next,
                                                  1'b0, 1'b0};
                                n = n + 2'd1;
                                last_literal_next = run_header_next;
                            end
                        end
                        else if (!h[7] && (h < CNT_MAX_WHT))
                        begin
                            run_header_next = h + 8'd1;
                            bundle.res[n] = '{KIND_WRITE, header_addr_next, run_header_next,
                                              byte_count_next, 1'b0, 1'b0};
                            n = n + 2'd1;
                        end
                        else
                        begin
                            header_addr_next = header_addr_next + 1'b1;
                            run_header_next  = HDR_WHITE;
                            byte_count_next  = byte_count_next + 1'b1;
                            bundle.res[n] = '{KIND_WRITE, header_addr_next, run_header_next,
                                              byte_count_next, 1'b0, 1'b0};
                            n = n + 2'd1;
                        end
                    end

                    // raster position
                    if (32'(column_pos_reg) + 1 >= 32'(se))
                    begin
                        column_pos_next = '0;
                        row_pos_next    = row_pos_reg + 1'b1;
                    end
                    else
                    begin
                        column_pos_next = column_pos_reg + 1'b1;
                    end
                    done = 32'(row_pos_next) >= 32'(se) * 8;
                    for (int k = 0; k < MAX_RES; k++)
                    begin
                        bundle.res[k].done = done;
                        bundle.res[k].last = (2'(k) == (n - 2'd1));
                    end
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase
        bundle.n = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_header_reg   <= 8'h00;
            header_addr_reg  <= THUMB_BASE;
            last_literal_reg <= 8'h00;
            literal_addr_reg <= THUMB_BASE;
            byte_count_reg   <= THUMB_BASE;
            column_pos_reg   <= '0;
            row_pos_reg      <= '0;
            seed_pending_reg <= 1'b1;
        end
        else if (accept)
        begin
            run_header_reg   <= run_header_next;
            header_addr_reg  <= header_addr_next;
            last_literal_reg <= last_literal_next;
            literal_addr_reg <= literal_addr_next;
            byte_count_reg   <= byte_count_next;
            column_pos_reg   <= column_pos_next;
            row_pos_reg      <= row_pos_next;
            seed_pending_reg <= seed_pending_next;
        end
    end

endmodule

/* rtl/bsre_out_fifo.sv */
// result queue: takes up to three beats a cycle, gives one per pop
`timescale 1ns / 1ps

module bsre_out_fifo #(
    parameter int DEPTH = bsre_pkg::OUT_FIFO_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsre_pkg::bsre_bundle_t         push,
    input  logic                           pop,
    output bsre_pkg::bsre_result_t         head,
    output logic                           head_valid,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    import bsre_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsre_result_t     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (2'(k) < push.n)
            begin
                entry_reg[wr_ptr_reg + PTR_W'(k)] <= push.res[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/bsre_checker.sv */
// port-level checks on the encoder, bound to the top level
`timescale 1ns / 1ps

module bsre_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import bsre_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_WRITE) || (m_tuser == KIND_THUMB)
                     || (m_tuser == KIND_REJECT))
        else $error("output kind out of range");

    // a rejected byte only comes once the frame is full, alone
    a_reject_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_REJECT) |-> m_tdata[TD_DONE_BIT] && m_tlast
                                                 && (m_tdata[13:0] == 14'd0))
        else $error("rejected beat without frame done");

    a_thumb_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_THUMB) |-> m_tlast && (m_tdata[13:7] == 7'd0))
        else $error("thumbnail read beat malformed");

endmodule

bind bitmap_sketch_rle_encoder_unit bsre_checker u_bsre_checker (.*);
